FILE: sv/msie_pkg.sv
// Package for the MIPS subset instruction executor.
// Holds opcode and function codes, field widths and the result item layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msie_pkg;

	localparam int unsigned PC_BITS_DEF    = 16;
	localparam int unsigned WORD_W         = 32;
	localparam int unsigned REG_IDX_W      = 5;
	localparam int unsigned TARGET_W       = 26;
	localparam int unsigned OUT_PC_W       = 16;
	localparam int unsigned OUT_TDATA_W    = 128;
	localparam logic [TARGET_W-1:0] JUMP_BASE_RST = 26'd1048585;

	// Primary opcodes.
	localparam logic [5:0] OP_RTYPE = 6'd0;
	localparam logic [5:0] OP_J     = 6'd2;
	localparam logic [5:0] OP_BEQ   = 6'd4;
	localparam logic [5:0] OP_ADDI  = 6'd8;
	localparam logic [5:0] OP_SW    = 6'd43;

	// Function codes of R-type instructions.
	localparam logic [5:0] FN_END = 6'd12;
	localparam logic [5:0] FN_ADD = 6'd32;
	localparam logic [5:0] FN_SUB = 6'd34;
	localparam logic [5:0] FN_AND = 6'd36;
	localparam logic [5:0] FN_SLT = 6'd42;

	// Result item, last field (next_pc) in the lowest bits, padded to whole bytes.
	typedef struct packed {
		logic [6:0]           pad;
		logic [WORD_W-1:0]    store_data;
		logic [WORD_W-1:0]    store_addr;
		logic                 store_valid;
		logic [WORD_W-1:0]    reg_write_value;
		logic [REG_IDX_W-1:0] reg_write_index;
		logic                 reg_write_valid;
		logic                 illegal;
		logic                 halted;
		logic [OUT_PC_W-1:0]  next_pc;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/mips_subset_instruction_executor.sv
// Top level of the MIPS subset instruction executor: one instruction per item.
// Two register stages (operand read, then result). Throughput: one item per
// cycle unless m_axis_tready stalls the result stage; the register file bypasses
// the write of the item ahead to its reads. Reset clears pc, the halt flag and
// the register valid bits and loads jump_base with JUMP_BASE_RST, so every
// register reads as zero until written; no clearing pass is needed. Uses msie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mips_subset_instruction_executor #(
	parameter int unsigned PC_BITS = msie_pkg::PC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration: jump_base.
	input  wire logic                                cfg_we,
	input  wire logic [msie_pkg::TARGET_W-1:0]       cfg_wdata,
	// Input items.
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [msie_pkg::WORD_W-1:0]         s_axis_tdata, // instr_word
	// Result items.
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// next_pc, halted, illegal, reg_write_valid, reg_write_index,
	// reg_write_value, store_valid, store_addr, store_data, zero pad.
	output logic [msie_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

	import msie_pkg::*;

	localparam int unsigned NUM_REGS = 2 ** REG_IDX_W;

	logic [TARGET_W-1:0]  jump_base_q;
	logic [PC_BITS-1:0]   pc_q;
	logic                 halt_q;

	logic [WORD_W-1:0]    rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0]  rf_vld_q;

	// Operand read stage.
	logic                 valid_s1;
	logic [WORD_W-1:0]    instr_s1;
	logic [WORD_W-1:0]    mem_a_s1, mem_b_s1;
	logic                 vld_a_s1, vld_b_s1;
	logic                 fwd_a_s1, fwd_b_s1;
	logic [WORD_W-1:0]    fwd_val_s1;

	// Result register.
	logic                 out_valid_q;
	result_t              res_q;

	logic                 accept, adv;
	logic [REG_IDX_W-1:0] in_rs, in_rt;

	// Execute signals.
	logic [5:0]           op, fn;
	logic [REG_IDX_W-1:0] rs, rt, rd;
	logic [WORD_W-1:0]    imm, opa, opb, jmp_diff;
	logic [PC_BITS-1:0]   npc, pc_inc;
	logic                 halt_nxt;
	result_t              res;
	logic                 wr_en;

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_rs         = s_axis_tdata[25:21];
	assign in_rt         = s_axis_tdata[20:16];

	assign wr_en         = adv && res.reg_write_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_base_q <= JUMP_BASE_RST;
		end else if (cfg_we) begin
			jump_base_q <= cfg_wdata;
		end
	end

	// Register file storage, written at one address and read at two.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf_mem[res.reg_write_index] <= res.reg_write_value;
		end
		if (accept) begin
			mem_a_s1 <= rf_mem[in_rs];
			mem_b_s1 <= rf_mem[in_rt];
			instr_s1 <= s_axis_tdata;
		end
		if (accept && wr_en) begin
			fwd_val_s1 <= res.reg_write_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			valid_s1 <= 1'b0;
			vld_a_s1 <= 1'b0;
			vld_b_s1 <= 1'b0;
			fwd_a_s1 <= 1'b0;
			fwd_b_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				rf_vld_q[res.reg_write_index] <= 1'b1;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
				vld_a_s1 <= rf_vld_q[in_rs];
				vld_b_s1 <= rf_vld_q[in_rt];
				// The instruction leaving this cycle writes at the same edge, so the
				// memory read would miss it.
				fwd_a_s1 <= wr_en && (res.reg_write_index == in_rs);
				fwd_b_s1 <= wr_en && (res.reg_write_index == in_rt);
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign op  = instr_s1[31:26];
	assign rs  = instr_s1[25:21];
	assign rt  = instr_s1[20:16];
	assign rd  = instr_s1[15:11];
	assign fn  = instr_s1[5:0];
	assign imm = {{16{instr_s1[15]}}, instr_s1[15:0]};

	assign opa = fwd_a_s1 ? fwd_val_s1 : (vld_a_s1 ? mem_a_s1 : '0);
	assign opb = fwd_b_s1 ? fwd_val_s1 : (vld_b_s1 ? mem_b_s1 : '0);

	assign pc_inc   = pc_q + PC_BITS'(1);
	assign jmp_diff = {{(WORD_W-TARGET_W){1'b0}}, instr_s1[TARGET_W-1:0]}
		- {{(WORD_W-TARGET_W){1'b0}}, jump_base_q};

	always_comb begin
		res      = '0;
		npc      = pc_q;
		halt_nxt = halt_q;
		if (!halt_q) begin
			npc = pc_inc;
			unique case (op)
				OP_RTYPE: begin
					res.reg_write_index = rd;
					res.reg_write_valid = 1'b1;
					unique case (fn)
						FN_ADD: res.reg_write_value = opa + opb;
						FN_SUB: res.reg_write_value = opa - opb;
						FN_SLT: res.reg_write_value = {31'd0, $signed(opa) < $signed(opb)};
						FN_AND: res.reg_write_value = opa & opb;
						FN_END: begin
							res.reg_write_valid = 1'b0;
							res.reg_write_index = '0;
							halt_nxt            = 1'b1;
							npc                 = pc_q;
						end
						default: begin
							res.reg_write_valid = 1'b0;
							res.reg_write_index = '0;
							res.illegal         = 1'b1;
							halt_nxt            = 1'b1;
							npc                 = pc_q;
						end
					endcase
				end
				OP_ADDI: begin
					res.reg_write_valid = 1'b1;
					res.reg_write_index = rt;
					res.reg_write_value = opa + imm;
				end
				OP_SW: begin
					res.store_valid = 1'b1;
					res.store_addr  = opa + imm;
					res.store_data  = opb;
				end
				OP_J: begin
					npc = PC_BITS'(jmp_diff);
				end
				OP_BEQ: begin
					if (opa == opb) begin
						npc = PC_BITS'(WORD_W'(pc_q) + imm);
					end
				end
				default: begin
					res.illegal = 1'b1;
					halt_nxt    = 1'b1;
					npc         = pc_q;
				end
			endcase
		end
		res.next_pc = OUT_PC_W'(npc);
		res.halted  = halt_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			halt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				pc_q        <= npc;
				halt_q      <= halt_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;

	a_illegal_halts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.illegal |-> res_q.halted)
		else $error("illegal instruction reported without halt");

	a_write_store_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.reg_write_valid && res_q.store_valid))
		else $error("register write and store in one result");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q && $stable(pc_q))
		else $error("halted executor changed pc or left halt");

	a_no_write_halted: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !halt_q)
		else $error("register file written while halted");

	a_fwd_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		accept && wr_en |=> valid_s1)
		else $error("bypass captured without an item in the read stage");

endmodule

`default_nettype wire

FILE: sim/tb_mips_subset_instruction_executor.sv
// Testbench for mips_subset_instruction_executor: random and directed instruction
// streams, checked against an in-bench executor model with its own register file.
// Depends on msie_pkg and the executor RTL.
`timescale 1ns / 1ps

module tb_mips_subset_instruction_executor;
	import msie_pkg::*;

	localparam int CLK_PERIOD  = 4;
	localparam int TOTAL_ITEMS = 1150;
	localparam int NUM_PHASES  = 6;

	// Executor model plus the queue of results it predicts.
	class exec_scoreboard;
		logic [WORD_W-1:0]   regs [32];
		logic [OUT_PC_W-1:0] pc;
		logic                halt;
		logic [TARGET_W-1:0] jump_base;
		result_t             pending_results [$];
		int unsigned         mismatches;
		int unsigned         checked;

		function new();
			foreach (regs[i]) begin
				regs[i] = '0;
			end
			pc = '0;
			halt = 1'b0;
			jump_base = JUMP_BASE_RST;
			mismatches = 0;
			checked = 0;
		endfunction

		function result_t execute_instr(logic [WORD_W-1:0] w);
			logic [5:0]          op;
			logic [5:0]          fn;
			logic [4:0]          rs;
			logic [4:0]          rt;
			logic [4:0]          rd;
			logic [WORD_W-1:0]   a;
			logic [WORD_W-1:0]   b;
			logic [WORD_W-1:0]   imm;
			logic [TARGET_W-1:0] jdiff;
			logic [OUT_PC_W-1:0] npc;
			result_t             r;
			op = w[31:26];
			fn = w[5:0];
			rs = w[25:21];
			rt = w[20:16];
			rd = w[15:11];
			imm = {{16{w[15]}}, w[15:0]};
			a = regs[rs];
			b = regs[rt];
			r = '0;
			npc = pc;
			if (!halt) begin
				npc = pc + 16'd1;
				case (op)
					OP_RTYPE: begin
						r.reg_write_valid = 1'b1;
						r.reg_write_index = rd;
						case (fn)
							FN_ADD: r.reg_write_value = a + b;
							FN_SUB: r.reg_write_value = a - b;
							FN_SLT: r.reg_write_value = {31'd0, $signed(a) < $signed(b)};
							FN_AND: r.reg_write_value = a & b;
							FN_END: begin
								r.reg_write_valid = 1'b0;
								r.reg_write_index = '0;
								halt = 1'b1;
								npc = pc;
							end
							default: begin
								r.reg_write_valid = 1'b0;
								r.reg_write_index = '0;
								r.illegal = 1'b1;
								halt = 1'b1;
								npc = pc;
							end
						endcase
					end
					OP_ADDI: begin
						r.reg_write_valid = 1'b1;
						r.reg_write_index = rt;
						r.reg_write_value = a + imm;
					end
					OP_SW: begin
						r.store_valid = 1'b1;
						r.store_addr = a + imm;
						r.store_data = b;
					end
					OP_J: begin
						jdiff = w[25:0] - jump_base;
						npc = jdiff[OUT_PC_W-1:0];
					end
					// The branch offset is added to the pc of the branch itself.
					OP_BEQ: begin
						if (a == b) begin
							npc = pc + w[15:0];
						end
					end
					default: begin
						r.illegal = 1'b1;
						halt = 1'b1;
						npc = pc;
					end
				endcase
				if (r.reg_write_valid) begin
					regs[r.reg_write_index] = r.reg_write_value;
				end
				pc = npc;
			end
			r.next_pc = npc;
			r.halted = halt;
			return r;
		endfunction

		function void note_instr(logic [WORD_W-1:0] w);
			pending_results.push_back(execute_instr(w));
		endfunction

		local function void compare_field(string name, logic [WORD_W-1:0] want,
				logic [WORD_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result item arrived with no instruction outstanding");
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			checked++;
			compare_field("next_pc", 32'(want.next_pc), 32'(got.next_pc));
			compare_field("halted", 32'(want.halted), 32'(got.halted));
			compare_field("illegal", 32'(want.illegal), 32'(got.illegal));
			compare_field("reg_write_valid", 32'(want.reg_write_valid),
				32'(got.reg_write_valid));
			compare_field("reg_write_index", 32'(want.reg_write_index),
				32'(got.reg_write_index));
			compare_field("reg_write_value", want.reg_write_value, got.reg_write_value);
			compare_field("store_valid", 32'(want.store_valid), 32'(got.store_valid));
			compare_field("store_addr", want.store_addr, got.store_addr);
			compare_field("store_data", want.store_data, got.store_data);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [TARGET_W-1:0]    cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [WORD_W-1:0]      s_axis_tdata = '0;   // instr_word
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// next_pc, halted, illegal, reg_write_valid, reg_write_index,
	// reg_write_value, store_valid, store_addr, store_data, zero pad.
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	exec_scoreboard book = new();
	logic               src_idle_on = 1'b0;
	logic               sink_stall_on = 1'b0;
	int unsigned        instrs_sent = 0;
	int unsigned        ignored_sent = 0;
	int unsigned        bases_used = 1;

	mips_subset_instruction_executor u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			book.check_result(result_t'(m_axis_tdata));
		end
	end

	// Result side: ready drops in bursts while stalling is enabled.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_stall_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [WORD_W-1:0] r_type(logic [5:0] fn, logic [4:0] rs,
			logic [4:0] rt, logic [4:0] rd);
		return {OP_RTYPE, rs, rt, rd, 5'($urandom), fn};
	endfunction

	function automatic logic [WORD_W-1:0] i_type(logic [5:0] op, logic [4:0] rs,
			logic [4:0] rt, logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	// Half the picks come from a few low registers so that operands often depend
	// on the instruction just before.
	function automatic logic [4:0] pick_reg();
		if ($urandom_range(0, 1) == 1) begin
			return 5'($urandom_range(0, 7));
		end
		return 5'($urandom);
	endfunction

	function automatic logic [15:0] pick_imm();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'hffff;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] rand_legal_instr();
		int unsigned sel;
		logic [5:0]  fn;
		logic [4:0]  rs;
		sel = $urandom_range(0, 99);
		rs = pick_reg();
		if (sel < 45) begin
			case ($urandom_range(0, 3))
				0: fn = FN_ADD;
				1: fn = FN_SUB;
				2: fn = FN_SLT;
				default: fn = FN_AND;
			endcase
			return r_type(fn, rs, pick_reg(), pick_reg());
		end else if (sel < 65) begin
			return i_type(OP_ADDI, rs, pick_reg(), pick_imm());
		end else if (sel < 78) begin
			return i_type(OP_SW, rs, pick_reg(), pick_imm());
		end else if (sel < 92) begin
			return i_type(OP_BEQ, rs, ($urandom_range(0, 2) == 0) ? rs : pick_reg(),
				pick_imm());
		end
		case ($urandom_range(0, 5))
			0: return {OP_J, 26'h0000000};
			1: return {OP_J, 26'h3ffffff};
			default: return {OP_J, 26'($urandom)};
		endcase
	endfunction

	task automatic send_instr(input logic [WORD_W-1:0] w);
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		book.note_instr(w);
		instrs_sent++;
	endtask

	// Clear a register, load a seed and keep doubling it, which walks the value
	// into the sign bit and through signed overflow.
	task automatic send_doubling_chain();
		logic [4:0]  rx;
		logic [4:0]  ry;
		logic [15:0] seed;
		int unsigned steps;
		rx = pick_reg();
		ry = pick_reg();
		case ($urandom_range(0, 3))
			0: seed = 16'h8000;
			1: seed = 16'h0001;
			2: seed = 16'h7fff;
			default: seed = 16'($urandom);
		endcase
		steps = ($urandom_range(0, 1) == 1) ? 16 : $urandom_range(1, 20);
		send_instr(r_type(FN_SUB, ry, ry, rx));
		send_instr(i_type(OP_ADDI, rx, rx, seed));
		repeat (steps) send_instr(r_type(FN_ADD, rx, rx, rx));
		if ($urandom_range(0, 1) == 1) begin
			send_instr(i_type(OP_ADDI, rx, rx, 16'hffff));
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (book.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_jump_base(input logic [TARGET_W-1:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.jump_base = v;
		bases_used++;
	endtask

	initial begin
		int unsigned         phase_end;
		logic [5:0]          bad_code;
		logic [TARGET_W-1:0] base;
		string               halt_kind;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, run with the jump base left at its reset value.
		send_instr(i_type(OP_ADDI, 5'd0, 5'd1, 16'h7fff));
		send_instr(i_type(OP_ADDI, 5'd0, 5'd2, 16'h8000));
		send_instr(r_type(FN_ADD, 5'd1, 5'd2, 5'd3));
		send_instr(r_type(FN_SUB, 5'd2, 5'd1, 5'd4));
		send_instr(r_type(FN_SLT, 5'd2, 5'd1, 5'd5));
		send_instr(r_type(FN_SLT, 5'd1, 5'd2, 5'd6));
		send_instr(r_type(FN_AND, 5'd3, 5'd1, 5'd7));
		send_instr(i_type(OP_SW, 5'd2, 5'd3, 16'h8000));
		send_instr(i_type(OP_SW, 5'd0, 5'd1, 16'h7fff));
		send_instr(i_type(OP_BEQ, 5'd1, 5'd1, 16'h0002));
		send_instr(i_type(OP_BEQ, 5'd1, 5'd2, 16'h8000));
		send_instr(i_type(OP_BEQ, 5'd0, 5'd0, 16'hffff));
		send_instr({OP_J, 26'h0000000});
		send_instr({OP_J, 26'h3ffffff});
		// r0 is an ordinary register here: write it, then read it back.
		send_instr(i_type(OP_ADDI, 5'd1, 5'd0, 16'h0001));
		send_instr(r_type(FN_ADD, 5'd0, 5'd0, 5'd8));
		send_instr(r_type(FN_SUB, 5'd3, 5'd2, 5'd31));
		send_instr(i_type(OP_ADDI, 5'd31, 5'd31, 16'hffff));

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				drain_results();
				case (p)
					1: base = '0;
					2: base = 26'h3ffffff;
					4: base = 26'd1;
					default: base = 26'($urandom);
				endcase
				set_jump_base(base);
			end
			src_idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
			sink_stall_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
			phase_end = (p + 1) * TOTAL_ITEMS / NUM_PHASES;
			while (instrs_sent < phase_end) begin
				if ($urandom_range(0, 19) == 0) begin
					send_doubling_chain();
				end else begin
					send_instr(rand_legal_instr());
				end
			end
		end

		// A halt can only happen once per run, so the kind is drawn at random.
		case ($urandom_range(0, 2))
			0: begin
				halt_kind = "end instruction";
				send_instr(r_type(FN_END, pick_reg(), pick_reg(), pick_reg()));
			end
			1: begin
				halt_kind = "illegal opcode";
				do begin
					bad_code = 6'($urandom);
				end while (bad_code inside {OP_RTYPE, OP_J, OP_BEQ, OP_ADDI, OP_SW});
				send_instr({bad_code, 26'($urandom)});
			end
			default: begin
				halt_kind = "illegal function code";
				do begin
					bad_code = 6'($urandom);
				end while (bad_code inside {FN_ADD, FN_SUB, FN_SLT, FN_AND, FN_END});
				send_instr(r_type(bad_code, pick_reg(), pick_reg(), pick_reg()));
			end
		endcase

		// Everything after the halt is ignored; full random words toggle every bit.
		repeat (16) begin
			send_instr($urandom);
			ignored_sent++;
		end
		send_instr(r_type(FN_END, 5'd0, 5'd0, 5'd0));
		send_instr(32'hffffffff);
		ignored_sent += 2;

		drain_results();
		repeat (10) @(posedge clk);
		$display("Checked %0d results from %0d instructions under %0d jump base values.",
			book.checked, instrs_sent, bases_used);
		$display("Run stopped by an %s; %0d later instructions were ignored while halted.",
			halt_kind, ignored_sent);
		if (book.mismatches == 0 && book.pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
